// File: hw/rtl/pms_pkg.sv
package pms_pkg;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_WRITE = 2'd3
	} op_t;

	localparam int ADDR_W     = 4;
	localparam int APB_DATA_W = 32;
	localparam int IN_DATA_W  = 40;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 16;
	localparam int ENTRY_W    = 32;

	localparam logic [1:0] REG_NOTE_COUNT   = 2'd0;
	localparam logic [1:0] REG_SPEED_FACTOR = 2'd1;
	localparam logic [1:0] REG_VOLUME_SHIFT = 2'd2;

	localparam logic [7:0] NOTE_COUNT_RST   = 8'd79;
	localparam logic [3:0] SPEED_FACTOR_RST = 4'd4;
	localparam logic [2:0] VOLUME_SHIFT_RST = 3'd2;

	localparam logic [19:0] DUR_MAX  = 20'hFFFFF;
	localparam logic [8:0]  CNT9_MAX = 9'h1FF;

	typedef struct packed {
		logic [7:0] note_count;
		logic [3:0] speed_factor;
		logic [2:0] volume_shift;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  strength;
		logic [7:0]  period;
		logic [15:0] duration;
	} entry_t;

endpackage

// File: hw/rtl/pms_ram.sv
module pms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/pms_cfg.sv
module pms_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [pms_pkg::ADDR_W-1:0]       paddr,
	input  logic [pms_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [pms_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	output pms_pkg::cfg_t                    cfg
);

	pms_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.note_count   <= pms_pkg::NOTE_COUNT_RST;
			cfg_q.speed_factor <= pms_pkg::SPEED_FACTOR_RST;
			cfg_q.volume_shift <= pms_pkg::VOLUME_SHIFT_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				pms_pkg::REG_NOTE_COUNT:   cfg_q.note_count   <= pwdata[7:0];
				pms_pkg::REG_SPEED_FACTOR: cfg_q.speed_factor <= pwdata[3:0];
				pms_pkg::REG_VOLUME_SHIFT: cfg_q.volume_shift <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			pms_pkg::REG_NOTE_COUNT:
				prdata = {24'd0, cfg_q.note_count};
			pms_pkg::REG_SPEED_FACTOR:
				prdata = {28'd0, cfg_q.speed_factor};
			pms_pkg::REG_VOLUME_SHIFT:
				prdata = {29'd0, cfg_q.volume_shift};
			default:
				prdata = '0;
		endcase
	end

endmodule

// File: hw/rtl/pms_core.sv
module pms_core #(
	parameter int TABLE_DEPTH = 128
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pms_pkg::cfg_t                     cfg,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [pms_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic [pms_pkg::IN_USER_W-1:0]     s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [pms_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                              mem_we,
	output logic [$clog2(TABLE_DEPTH)-1:0]    mem_waddr,
	output logic [pms_pkg::ENTRY_W-1:0]       mem_wdata,
	output logic [$clog2(TABLE_DEPTH)-1:0]    mem_raddr,
	input  logic [pms_pkg::ENTRY_W-1:0]       mem_rdata
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CMP_W = (IDX_W + 1 > 8) ? IDX_W + 1 : 8;

	logic                 valid_s1;
	pms_pkg::op_t         op_s1;
	logic [6:0]           idx_s1;
	logic [15:0]          dur_s1;
	logic [7:0]           per_s1;
	logic [7:0]           str_s1;

	logic                 out_valid_q;
	logic                 proc;

	logic [IDX_W-1:0]     play_idx_q, play_idx_d;
	logic [19:0]          dur_cnt_q, dur_cnt_d;
	logic [8:0]           per_cnt_q, per_cnt_d;
	logic [8:0]           str_cnt_q, str_cnt_d;
	logic                 running_q, running_d;
	logic                 level_q, level_d;

	logic                 fwd_q;
	pms_pkg::entry_t      fwd_data_q;

	pms_pkg::entry_t      entry;
	logic [19:0]          dur_lim;
	logic [7:0]           str_eff;
	logic [19:0]          dur_inc;
	logic [8:0]           per_inc;
	logic [8:0]           str_inc;
	logic [CMP_W-1:0]     idx_inc;
	logic [7:0]           nc_len;
	logic [CMP_W-1:0]     song_len;
	logic [CMP_W-1:0]     wr_idx_ext;
	logic                 wr_ok;

	assign proc     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || proc;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, 7'(play_idx_q), running_q, level_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1  <= pms_pkg::op_t'(s_tuser[1:0]);
			idx_s1 <= s_tdata[6:0];
			dur_s1 <= s_tdata[22:7];
			per_s1 <= s_tdata[30:23];
			str_s1 <= s_tdata[38:31];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The table is read at the next index, so its registered output always
	// belongs to the note now playing; a write to that entry is forwarded.
	assign entry    = fwd_q ? fwd_data_q : pms_pkg::entry_t'(mem_rdata);
	assign dur_lim  = {4'd0, entry.duration} * {16'd0, cfg.speed_factor};
	assign str_eff  = entry.strength >> cfg.volume_shift;
	assign dur_inc  = (dur_cnt_q == pms_pkg::DUR_MAX) ? dur_cnt_q : dur_cnt_q + 20'd1;
	assign per_inc  = (per_cnt_q == pms_pkg::CNT9_MAX) ? per_cnt_q : per_cnt_q + 9'd1;
	assign str_inc  = (str_cnt_q == pms_pkg::CNT9_MAX) ? str_cnt_q : str_cnt_q + 9'd1;
	assign idx_inc  = CMP_W'(play_idx_q) + CMP_W'(1);
	assign nc_len   = (cfg.note_count == 8'd0) ? 8'd1 : cfg.note_count;
	assign song_len = (CMP_W'(nc_len) > CMP_W'(TABLE_DEPTH)) ?
		CMP_W'(TABLE_DEPTH) : CMP_W'(nc_len);

	assign wr_idx_ext = CMP_W'(idx_s1);
	assign wr_ok      = wr_idx_ext < CMP_W'(TABLE_DEPTH);
	assign mem_waddr  = IDX_W'(wr_idx_ext);
	assign mem_wdata  = {str_s1, per_s1, dur_s1};
	assign mem_raddr  = play_idx_d;

	always_comb begin
		play_idx_d = play_idx_q;
		dur_cnt_d  = dur_cnt_q;
		per_cnt_d  = per_cnt_q;
		str_cnt_d  = str_cnt_q;
		running_d  = running_q;
		level_d    = level_q;
		mem_we     = 1'b0;
		if (proc) begin
			case (op_s1)
				pms_pkg::OP_TICK: begin
					if (running_q) begin
						dur_cnt_d = dur_inc;
						per_cnt_d = per_inc;
						str_cnt_d = str_inc;
						level_d   = str_inc <= {1'b0, str_eff};
						if (per_inc > {1'b0, entry.period}) begin
							per_cnt_d = '0;
							str_cnt_d = '0;
							if (dur_inc > dur_lim) begin
								dur_cnt_d = '0;
								if (idx_inc >= song_len) begin
									play_idx_d = '0;
									running_d  = 1'b0;
									level_d    = 1'b0;
								end else begin
									play_idx_d = IDX_W'(idx_inc);
								end
							end
						end
					end
				end
				pms_pkg::OP_START: begin
					running_d = 1'b1;
				end
				pms_pkg::OP_STOP: begin
					play_idx_d = '0;
					dur_cnt_d  = '0;
					per_cnt_d  = '0;
					str_cnt_d  = '0;
					running_d  = 1'b0;
					level_d    = 1'b0;
				end
				pms_pkg::OP_WRITE: begin
					mem_we = wr_ok;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_idx_q <= '0;
			dur_cnt_q  <= '0;
			per_cnt_q  <= '0;
			str_cnt_q  <= '0;
			running_q  <= 1'b0;
			level_q    <= 1'b0;
			fwd_q      <= 1'b0;
		end else begin
			play_idx_q <= play_idx_d;
			dur_cnt_q  <= dur_cnt_d;
			per_cnt_q  <= per_cnt_d;
			str_cnt_q  <= str_cnt_d;
			running_q  <= running_d;
			level_q    <= level_d;
			fwd_q      <= mem_we && (mem_waddr == play_idx_d);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= pms_pkg::entry_t'(mem_wdata);
	end

endmodule

// File: hw/rtl/pwm_melody_sequencer_unit.sv
// An accepted input beat passes from the input register to the result register, which offers its result beat.
// One beat per clock unless m_tready holds the result beat; the input register, the note table's
// registered read and the result register keep every tick in step.
// Reset clears the counters, the note index, playback and the output valid,
// and loads the register defaults; the note table holds nothing until written.
module pwm_melody_sequencer_unit #(
	parameter int TABLE_DEPTH = 128
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [pms_pkg::ADDR_W-1:0]        paddr,
	input  logic [pms_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [pms_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// From bit 0: note_index[6:0], note_duration[15:0], note_period[7:0],
	// note_strength[7:0], zero pad.
	input  logic [pms_pkg::IN_DATA_W-1:0]     s_tdata,
	// From bit 0: operation[1:0].
	input  logic [pms_pkg::IN_USER_W-1:0]     s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// From bit 0: pwm_level, playing, current_index[6:0], zero pad.
	output logic [pms_pkg::OUT_DATA_W-1:0]    m_tdata
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	pms_pkg::cfg_t               cfg;
	logic                        mem_we;
	logic [IDX_W-1:0]            mem_waddr;
	logic [pms_pkg::ENTRY_W-1:0] mem_wdata;
	logic [IDX_W-1:0]            mem_raddr;
	logic [pms_pkg::ENTRY_W-1:0] mem_rdata;

	pms_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pms_ram #(
		.WIDTH (pms_pkg::ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	pms_core #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

endmodule

// File: verif/tb_pwm_melody_sequencer_unit.sv
module tb_pwm_melody_sequencer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = 128;

	typedef struct packed {
		pms_pkg::op_t    op;
		logic [6:0]      idx;
		pms_pkg::entry_t ent;
	} note_cmd_t;

	// Same layout as the low bits of m_tdata.
	typedef struct packed {
		logic [6:0] index;
		logic       playing;
		logic       level;
	} player_status_t;

	typedef struct {
		note_cmd_t      cmd;
		bit             typed;
		player_status_t want;
	} cue_t;

	logic                           clk;
	logic                           arst_n = 1'b0;
	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [pms_pkg::ADDR_W-1:0]     paddr = '0;
	logic [pms_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [pms_pkg::APB_DATA_W-1:0] prdata;
	logic                           pready;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	// From bit 0: note_index[6:0], note_duration[15:0], note_period[7:0],
	// note_strength[7:0], zero pad.
	logic [pms_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	// From bit 0: operation[1:0].
	logic [pms_pkg::IN_USER_W-1:0]  s_tuser = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	// From bit 0: pwm_level, playing, current_index[6:0], zero pad.
	logic [pms_pkg::OUT_DATA_W-1:0] m_tdata;

	pwm_melody_sequencer_unit #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	pms_pkg::entry_t tone_table [TABLE_DEPTH];
	bit              tone_written [TABLE_DEPTH];
	logic [6:0]      tone_idx = '0;
	logic [19:0]     dur_cnt = '0;
	logic [8:0]      per_cnt = '0;
	logic [8:0]      str_cnt = '0;
	logic            is_playing = 1'b0;
	logic            pin_level = 1'b0;
	pms_pkg::cfg_t   cfg = '{pms_pkg::NOTE_COUNT_RST, pms_pkg::SPEED_FACTOR_RST,
		pms_pkg::VOLUME_SHIFT_RST};

	player_status_t status_q [$];
	cue_t           script [$];
	bit             typed_pending = 1'b0;
	player_status_t typed_want = '0;
	bit             calm = 1'b0;
	int             hold_left = 0;
	int             mismatches = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic int song_span();
		if (cfg.note_count == 0)
			return 1;
		if (cfg.note_count > TABLE_DEPTH)
			return TABLE_DEPTH;
		return cfg.note_count;
	endfunction

	function automatic player_status_t step_player(note_cmd_t c);
		pms_pkg::entry_t e;
		int dur_lim, per_lim, str_lim;
		case (c.op)
			pms_pkg::OP_TICK: if (is_playing) begin
				e = tone_table[tone_idx];
				dur_lim = int'(e.duration) * int'(cfg.speed_factor);
				per_lim = e.period;
				str_lim = e.strength >> cfg.volume_shift;
				if (dur_cnt != pms_pkg::DUR_MAX)
					dur_cnt++;
				if (per_cnt != pms_pkg::CNT9_MAX)
					per_cnt++;
				if (str_cnt != pms_pkg::CNT9_MAX)
					str_cnt++;
				pin_level = (str_cnt <= str_lim);
				if (per_cnt > per_lim) begin
					per_cnt = '0;
					str_cnt = '0;
					if (dur_cnt > dur_lim) begin
						dur_cnt = '0;
						if (tone_idx + 1 >= song_span()) begin
							tone_idx = '0;
							is_playing = 1'b0;
							pin_level = 1'b0;
						end else begin
							tone_idx++;
						end
					end
				end
			end
			pms_pkg::OP_START: is_playing = 1'b1;
			pms_pkg::OP_STOP: begin
				is_playing = 1'b0;
				pin_level = 1'b0;
				tone_idx = '0;
				dur_cnt = '0;
				per_cnt = '0;
				str_cnt = '0;
			end
			pms_pkg::OP_WRITE: begin
				tone_table[c.idx] = c.ent;
				tone_written[c.idx] = 1'b1;
			end
			default: ;
		endcase
		return '{index: tone_idx, playing: is_playing, level: pin_level};
	endfunction

	task automatic flag_mismatch(string what, int got, int want);
		$display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	always @(posedge clk) begin : watch
		note_cmd_t      c;
		player_status_t got, want;
		if (arst_n && s_tvalid && s_tready) begin
			c.op = pms_pkg::op_t'(s_tuser);
			c.idx = s_tdata[6:0];
			c.ent = s_tdata[38:7];
			want = step_player(c);
			status_q.push_back(typed_pending ? typed_want : want);
		end
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[8:0];
			if (status_q.size() == 0) begin
				flag_mismatch("result beat with nothing pending", got, 0);
			end else begin
				want = status_q.pop_front();
				if (got.level !== want.level)
					flag_mismatch("pwm_level", got.level, want.level);
				if (got.playing !== want.playing)
					flag_mismatch("playing", got.playing, want.playing);
				if (got.index !== want.index)
					flag_mismatch("current_index", got.index, want.index);
			end
		end
	end

	function automatic int stall_length();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	always @(negedge clk) begin
		if (!calm && hold_left == 0 && $urandom_range(0, 99) < 25)
			hold_left = stall_length();
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic write_reg(logic [1:0] id, logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {id, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (id)
			pms_pkg::REG_NOTE_COUNT:   cfg.note_count = value[7:0];
			pms_pkg::REG_SPEED_FACTOR: cfg.speed_factor = value[3:0];
			pms_pkg::REG_VOLUME_SHIFT: cfg.volume_shift = value[2:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic send_cmd(note_cmd_t c, bit typed, player_status_t want);
		int gap;
		gap = (!calm && $urandom_range(0, 99) < 30) ? stall_length() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= c.op;
		s_tdata <= {1'b0, c.ent, c.idx};
		typed_pending = typed;
		typed_want = want;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		@(negedge clk);
	endtask

	task automatic settle();
		while (status_q.size() != 0)
			@(posedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic cue(pms_pkg::op_t op, logic [6:0] idx, logic [15:0] dur, logic [7:0] per,
			logic [7:0] str, bit typed, logic lvl, logic ply, logic [6:0] cur);
		cue_t row;
		row.cmd = '{op: op, idx: idx, ent: '{strength: str, period: per, duration: dur}};
		row.typed = typed;
		row.want = '{index: cur, playing: ply, level: lvl};
		script.push_back(row);
	endtask

	function automatic pms_pkg::entry_t random_entry();
		pms_pkg::entry_t e;
		e.duration = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(0, 3)) : 16'($urandom);
		e.period = ($urandom_range(0, 99) < 75) ? 8'($urandom_range(0, 15)) : 8'($urandom);
		e.strength = 8'($urandom);
		return e;
	endfunction

	task automatic play_random(int quota);
		int counted, r;
		bit was_playing;
		note_cmd_t c, fill;
		counted = 0;
		while (counted < quota) begin
			if (counted % 40 == 0)
				calm = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			c.idx = 7'($urandom);
			c.ent = pms_pkg::entry_t'($urandom);
			if (is_playing)
				c.op = r < 80 ? pms_pkg::OP_TICK : r < 92 ? pms_pkg::OP_WRITE :
					r < 96 ? pms_pkg::OP_START : pms_pkg::OP_STOP;
			else
				c.op = r < 55 ? pms_pkg::OP_START : r < 75 ? pms_pkg::OP_WRITE :
					r < 88 ? pms_pkg::OP_TICK : pms_pkg::OP_STOP;
			if (c.op == pms_pkg::OP_WRITE) begin
				if ($urandom_range(0, 99) < 70)
					c.idx = 7'($urandom_range(0, song_span() - 1));
				c.ent = random_entry();
			end
			// The note about to sound must hold defined values.
			if (c.op == pms_pkg::OP_TICK && is_playing && !tone_written[tone_idx]) begin
				fill = '{op: pms_pkg::OP_WRITE, idx: tone_idx, ent: random_entry()};
				send_cmd(fill, 1'b0, '0);
				counted++;
			end
			was_playing = is_playing;
			send_cmd(c, 1'b0, '0);
			if (c.op != pms_pkg::OP_TICK || was_playing)
				counted++;
		end
		s_tvalid <= 1'b0;
	endtask

	initial begin : run
		int nc, sp, vs;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_reg(pms_pkg::REG_NOTE_COUNT, 2);
		write_reg(pms_pkg::REG_SPEED_FACTOR, 1);
		write_reg(pms_pkg::REG_VOLUME_SHIFT, 0);

		cue(pms_pkg::OP_TICK,    0, 16'h0000,   0,   0, 1, 0, 0, 0);
		cue(pms_pkg::OP_STOP,  127, 16'hFFFF, 255, 255, 1, 0, 0, 0);
		cue(pms_pkg::OP_WRITE, 127, 16'hFFFF, 255, 255, 1, 0, 0, 0);
		cue(pms_pkg::OP_WRITE,   0, 16'h0000,   0,   0, 1, 0, 0, 0);
		cue(pms_pkg::OP_WRITE,   1, 16'h0001,   2, 255, 1, 0, 0, 0);
		cue(pms_pkg::OP_START,   0, 16'h0000,   0,   0, 1, 0, 1, 0);
		cue(pms_pkg::OP_START,  99, 16'h1234,  77,  11, 1, 0, 1, 0);
		cue(pms_pkg::OP_TICK,    0, 16'h0000,   0,   0, 1, 0, 1, 1);
		cue(pms_pkg::OP_TICK,    0, 16'h0000,   0,   0, 1, 1, 1, 1);
		cue(pms_pkg::OP_WRITE,   1, 16'h0001,   2,   0, 1, 1, 1, 1);
		cue(pms_pkg::OP_TICK,    0, 16'h0000,   0,   0, 1, 0, 1, 1);
		cue(pms_pkg::OP_TICK,    0, 16'h0000,   0,   0, 1, 0, 0, 0);
		cue(pms_pkg::OP_START,   0, 16'h0000,   0,   0, 1, 0, 1, 0);
		cue(pms_pkg::OP_TICK,    0, 16'h0000,   0,   0, 1, 0, 1, 1);
		cue(pms_pkg::OP_STOP,    0, 16'h0000,   0,   0, 1, 0, 0, 0);
		cue(pms_pkg::OP_WRITE,   0, 16'h0002,   1, 128, 0, 0, 0, 0);
		cue(pms_pkg::OP_WRITE,   1, 16'h0000,   3,  64, 0, 0, 0, 0);
		cue(pms_pkg::OP_START,   0, 16'h0000,   0,   0, 0, 0, 0, 0);
		repeat (5)
			cue(pms_pkg::OP_TICK, 0, 16'h0000, 0, 0, 0, 0, 0, 0);
		cue(pms_pkg::OP_WRITE,   0, 16'hFFFF,   0, 255, 0, 0, 0, 0);
		repeat (3)
			cue(pms_pkg::OP_TICK, 0, 16'h0000, 0, 0, 0, 0, 0, 0);
		cue(pms_pkg::OP_STOP,    0, 16'h0000,   0,   0, 0, 0, 0, 0);

		foreach (script[i])
			send_cmd(script[i].cmd, script[i].typed, script[i].want);
		s_tvalid <= 1'b0;
		settle();

		for (int p = 0; p < 7; p++) begin
			case (p)
				0: begin nc = 4; sp = 1; vs = 0; end
				1: begin nc = 0; sp = 0; vs = 7; end
				2: begin nc = 128; sp = 15; vs = 3; end
				3: begin nc = 255; sp = 2; vs = 1; end
				4: begin nc = 3; sp = $urandom_range(1, 15); vs = $urandom_range(0, 7); end
				5: begin nc = 1; sp = 1; vs = 0; end
				default: begin
					nc = $urandom_range(1, 16);
					sp = $urandom_range(0, 15);
					vs = $urandom_range(0, 7);
				end
			endcase
			write_reg(pms_pkg::REG_NOTE_COUNT, nc);
			write_reg(pms_pkg::REG_SPEED_FACTOR, sp);
			write_reg(pms_pkg::REG_VOLUME_SHIFT, vs);
			play_random(72);
			settle();
		end

		repeat (3) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
